@@ src/bsfd_pkg.sv @@
// ----------------------------------------------------------------------------
// bsfd_pkg
// Shared types, constants and the BCD field decode function for the deframer.
// ----------------------------------------------------------------------------
package bsfd_pkg;

  localparam int FRAME_BYTES = 29;
  localparam int FIELD_COUNT = 9;
  localparam int FIELD_BYTES = 3;
  localparam int DATA_BYTES  = FIELD_COUNT * FIELD_BYTES;
  localparam int LAST_POS    = FRAME_BYTES - 1;
  localparam int POS_W       = $clog2(FRAME_BYTES);
  localparam int VAL_W       = 19;

  localparam logic [7:0] HEADER_BYTE = 8'h84;

  localparam logic [VAL_W-1:0] WEIGHT_10000 = VAL_W'(10000);
  localparam logic [VAL_W-1:0] WEIGHT_1000  = VAL_W'(1000);
  localparam logic [VAL_W-1:0] WEIGHT_100   = VAL_W'(100);
  localparam logic [VAL_W-1:0] WEIGHT_10    = VAL_W'(10);

  typedef logic [7:0]                   rx_byte_t;
  typedef logic [POS_W-1:0]             pos_t;
  typedef logic signed [VAL_W-1:0]      val_t;
  typedef logic [DATA_BYTES-1:0][7:0]   frame_t;

  typedef struct packed {
    logic load;
    pos_t pos;
  } fr_ctl_t;

  function automatic val_t decode_field(input rx_byte_t b0, input rx_byte_t b1,
                                        input rx_byte_t b2);
    logic [VAL_W-1:0] mag;
    logic [VAL_W-1:0] res;
    mag = VAL_W'(b0[3:0]) * WEIGHT_10000
        + VAL_W'(b1[7:4]) * WEIGHT_1000
        + VAL_W'(b1[3:0]) * WEIGHT_100
        + VAL_W'(b2[7:4]) * WEIGHT_10
        + VAL_W'(b2[3:0]);
    if (b0[7:4] != 4'd0) begin
      res = -mag;
    end else begin
      res = mag;
    end
    return val_t'(res);
  endfunction

endpackage

@@ src/bsfd_if.sv @@
// ----------------------------------------------------------------------------
// bsfd_in_if / bsfd_out_if
// Valid/ready channels for received bytes and decoded frame results.
// ----------------------------------------------------------------------------
interface bsfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bsfd_out_if;
  logic              valid;
  logic              ready;
  logic signed [18:0] roll_angle;
  logic signed [18:0] pitch_angle;
  logic signed [18:0] yaw_angle;
  logic signed [18:0] accel_x;
  logic signed [18:0] accel_y;
  logic signed [18:0] accel_z;
  logic signed [18:0] rate_x;
  logic signed [18:0] rate_y;
  logic signed [18:0] rate_z;

  modport source (output valid, output roll_angle, output pitch_angle, output yaw_angle,
                  output accel_x, output accel_y, output accel_z,
                  output rate_x, output rate_y, output rate_z, input ready);
  modport sink   (input valid, input roll_angle, input pitch_angle, input yaw_angle,
                  input accel_x, input accel_y, input accel_z,
                  input rate_x, input rate_y, input rate_z, output ready);
endinterface

@@ src/bsfd_framer.sv @@
// ----------------------------------------------------------------------------
// bsfd_framer
// Header hunt, byte position count and data byte shift register.
// ----------------------------------------------------------------------------
module bsfd_framer (
  input  logic                clk,
  input  logic                rst_n,
  bsfd_in_if.sink             in_bus,
  input  logic                busy,
  output bsfd_pkg::frame_t    store,
  output bsfd_pkg::fr_ctl_t   ctl
);
  import bsfd_pkg::*;

  pos_t   pos_r, pos_nxt;
  frame_t store_r;
  logic   xfer;
  logic   at_last;
  logic   shift_en;

  assign at_last      = (pos_r == pos_t'(LAST_POS));
  assign in_bus.ready = !at_last || !busy;
  assign xfer         = in_bus.valid && in_bus.ready;
  assign shift_en     = xfer && (pos_r != '0) && !at_last;

  always_comb begin
    pos_nxt = pos_r;
    if (xfer) begin
      if (pos_r == '0) begin
        if (in_bus.rx_byte == HEADER_BYTE) begin
          pos_nxt = pos_t'(1);
        end
      end else if (at_last) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + pos_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // shift toward index 0 so the first data byte lands lowest
  always_ff @(posedge clk) begin
    if (shift_en) begin
      store_r <= {in_bus.rx_byte, store_r[DATA_BYTES-1:1]};
    end
  end

  assign store    = store_r;
  assign ctl.load = xfer && at_last;
  assign ctl.pos  = pos_r;

endmodule

@@ src/bsfd_decoder.sv @@
// ----------------------------------------------------------------------------
// bsfd_decoder
// Nine parallel BCD sign-magnitude decoders feeding the result register.
// ----------------------------------------------------------------------------
module bsfd_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  bsfd_pkg::frame_t    store,
  input  bsfd_pkg::fr_ctl_t   ctl,
  output logic                busy,
  bsfd_out_if.source          out_bus
);
  import bsfd_pkg::*;

  val_t vals [FIELD_COUNT];
  val_t res_r [FIELD_COUNT];
  logic out_valid_r;

  always_comb begin
    for (int k = 0; k < FIELD_COUNT; k++) begin
      vals[k] = decode_field(store[k*FIELD_BYTES], store[k*FIELD_BYTES+1],
                             store[k*FIELD_BYTES+2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      res_r <= vals;
    end
  end

  assign busy                = out_valid_r && !out_bus.ready;
  assign out_bus.valid       = out_valid_r;
  assign out_bus.roll_angle  = res_r[0];
  assign out_bus.pitch_angle = res_r[1];
  assign out_bus.yaw_angle   = res_r[2];
  assign out_bus.accel_x     = res_r[3];
  assign out_bus.accel_y     = res_r[4];
  assign out_bus.accel_z     = res_r[5];
  assign out_bus.rate_x      = res_r[6];
  assign out_bus.rate_y      = res_r[7];
  assign out_bus.rate_z      = res_r[8];

endmodule

@@ src/bcd_sensor_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// bcd_sensor_frame_deframer
// The result is valid in the cycle after the transfer of a frame's last byte.
// Throughput: one byte per cycle; the last byte of a frame waits only while the
// previous result is still held in the result register.
// Reset clears the byte position and the result valid flag; the byte store is not reset.
// ----------------------------------------------------------------------------
module bcd_sensor_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  bsfd_in_if.sink     in_bus,
  bsfd_out_if.source  out_bus
);
  import bsfd_pkg::*;

  frame_t  store;
  fr_ctl_t ctl;
  logic    busy;

  bsfd_framer u_framer (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .busy   (busy),
    .store  (store),
    .ctl    (ctl)
  );

  bsfd_decoder u_decoder (
    .clk     (clk),
    .rst_n   (rst_n),
    .store   (store),
    .ctl     (ctl),
    .busy    (busy),
    .out_bus (out_bus)
  );

`ifndef ASSERT_OFF
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |-> !busy)
    else $error("frame completed while result register still held");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |=> out_bus.valid)
    else $error("result not presented after frame completion");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pos <= pos_t'(LAST_POS))
    else $error("byte position beyond frame length");

  a_stall_last: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> (ctl.pos == pos_t'(LAST_POS)))
    else $error("input stalled away from the last frame byte");
`endif

endmodule

@@ tb/bcd_sensor_frame_deframer_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bcd_sensor_frame_deframer_test
// Feeds header-synced BCD sensor frames and stray bytes into the deframer
// under shifting back-pressure, predicts each decoded frame from the byte
// transfers and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module bcd_sensor_frame_deframer_test;
  import bsfd_pkg::*;

  typedef logic [FIELD_COUNT-1:0][VAL_W-1:0] frame_vals_t;

  class frame_scoreboard;
    rx_byte_t    held [FRAME_BYTES];
    int unsigned fill;
    frame_vals_t due_frames [$];
    int unsigned errors;
    int unsigned frames_ok;
    int unsigned accepted;
    int unsigned dropped;
    string       field_name [FIELD_COUNT];

    function new();
      fill       = 0;
      errors     = 0;
      frames_ok  = 0;
      accepted   = 0;
      dropped    = 0;
      field_name = '{"roll_angle", "pitch_angle", "yaw_angle", "accel_x", "accel_y",
                     "accel_z", "rate_x", "rate_y", "rate_z"};
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function void note_byte(rx_byte_t b);
      frame_vals_t vals;
      int          mag;
      rx_byte_t    b0;
      rx_byte_t    b1;
      rx_byte_t    b2;
      accepted++;
      if (fill == 0 && b != HEADER_BYTE) begin
        dropped++;
        return;
      end
      held[fill] = b;
      fill++;
      if (fill < FRAME_BYTES) return;
      for (int k = 0; k < FIELD_COUNT; k++) begin
        b0  = held[1 + k * FIELD_BYTES];
        b1  = held[2 + k * FIELD_BYTES];
        b2  = held[3 + k * FIELD_BYTES];
        mag = int'(b0[3:0]) * 10000 + int'(b1[7:4]) * 1000 + int'(b1[3:0]) * 100
            + int'(b2[7:4]) * 10 + int'(b2[3:0]);
        if (b0[7:4] != 4'd0) mag = -mag;
        vals[k] = VAL_W'(mag);
      end
      due_frames.push_back(vals);
      fill = 0;
    endfunction

    function void check_result(frame_vals_t got);
      frame_vals_t want;
      bit          bad;
      if (due_frames.size() == 0) begin
        flag($sformatf("result transfer with no frame pending: %h", got));
        return;
      end
      want = due_frames.pop_front();
      bad  = 1'b0;
      for (int k = 0; k < FIELD_COUNT; k++) begin
        if (got[k] !== want[k]) begin
          bad = 1'b1;
          flag($sformatf("%s expected %0d, got %0d", field_name[k],
                         val_t'(want[k]), val_t'(got[k])));
        end
      end
      if (!bad) frames_ok++;
    endfunction

    function int unsigned pending();
      return due_frames.size();
    endfunction

    function void close();
      if (due_frames.size() != 0)
        flag($sformatf("%0d decoded frames never came out", due_frames.size()));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  bsfd_in_if  in_ch ();
  bsfd_out_if out_ch ();

  bcd_sensor_frame_deframer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_ch),
    .out_bus(out_ch)
  );

  frame_scoreboard sb = new();
  rx_byte_t        frame_buf [FRAME_BYTES];
  int unsigned     send_idle_pct = 11;
  int unsigned     recv_idle_pct = 85;
  int unsigned     hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("bcd_sensor_frame_deframer_test: FAIL");
    $finish;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_byte(in_ch.rx_byte);
      if (out_ch.valid && out_ch.ready)
        sb.check_result({out_ch.rate_z, out_ch.rate_y, out_ch.rate_x,
                         out_ch.accel_z, out_ch.accel_y, out_ch.accel_x,
                         out_ch.yaw_angle, out_ch.pitch_angle, out_ch.roll_angle});
    end
  end

  task automatic send_byte(input rx_byte_t b);
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid   <= 1'b0;
      in_ch.rx_byte <= rx_byte_t'($urandom);
      @(posedge clk);
    end
  endtask

  function automatic void put_field(input int k, input rx_byte_t b0, input rx_byte_t b1,
                                    input rx_byte_t b2);
    frame_buf[1 + k * FIELD_BYTES] = b0;
    frame_buf[2 + k * FIELD_BYTES] = b1;
    frame_buf[3 + k * FIELD_BYTES] = b2;
  endfunction

  function automatic rx_byte_t bcd_pair();
    return {4'($urandom_range(9)), 4'($urandom_range(9))};
  endfunction

  task automatic send_frame_buf();
    frame_buf[0] = HEADER_BYTE;
    for (int i = 0; i < FRAME_BYTES; i++) send_byte(frame_buf[i]);
  endtask

  task automatic send_noise(input int unsigned n);
    rx_byte_t b;
    repeat (n) begin
      b = rx_byte_t'($urandom);
      if (b == HEADER_BYTE) b = b ^ 8'h01;
      send_byte(b);
    end
  endtask

  task automatic send_random_frame();
    rx_byte_t corner_b0 [5];
    rx_byte_t corner_bx [3];
    corner_b0 = '{8'h00, 8'h0F, 8'hF0, 8'hFF, HEADER_BYTE};
    corner_bx = '{8'h00, 8'h99, 8'hFF};
    for (int k = 0; k < FIELD_COUNT; k++) begin
      case ($urandom_range(3))
        0: begin
          put_field(k, {4'h0, 4'($urandom_range(9))}, bcd_pair(), bcd_pair());
        end
        1: begin
          put_field(k, {4'($urandom_range(15, 1)), 4'($urandom_range(9))},
                    bcd_pair(), bcd_pair());
        end
        2: begin
          put_field(k, rx_byte_t'($urandom), rx_byte_t'($urandom), rx_byte_t'($urandom));
        end
        default: begin
          put_field(k, corner_b0[$urandom_range(4)], corner_bx[$urandom_range(2)],
                    corner_bx[$urandom_range(2)]);
        end
      endcase
    end
    frame_buf[LAST_POS] = rx_byte_t'($urandom);
    send_frame_buf();
  endtask

  task automatic wait_drain();
    int unsigned n;
    n = 0;
    do begin
      @(posedge clk);
      n++;
    end while (sb.pending() != 0 && n < 50000);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned s_pct, input int unsigned r_pct,
                           input int unsigned frames, input int unsigned hold);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    hold_left     = hold;
    repeat (frames) begin
      if ($urandom_range(3) == 0) send_noise($urandom_range(6, 1));
      send_random_frame();
    end
    in_ch.valid <= 1'b0;
    wait_drain();
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // drop stray bytes, including near misses of the header
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HEADER_BYTE ^ 8'h01);
    send_byte(HEADER_BYTE ^ 8'h80);

    for (int k = 0; k < FIELD_COUNT; k++) put_field(k, 8'h00, 8'h00, 8'h00);
    frame_buf[LAST_POS] = 8'h00;
    send_frame_buf();

    // largest magnitudes of both signs, header byte as spare byte
    for (int k = 0; k < FIELD_COUNT; k++) put_field(k, (k % 2) ? 8'hFF : 8'h0F, 8'hFF, 8'hFF);
    frame_buf[LAST_POS] = HEADER_BYTE;
    send_frame_buf();

    // negative zero, header byte in data, non-decimal nibbles, plain values
    put_field(0, 8'h10, 8'h00, 8'h00);
    put_field(1, 8'h20, 8'h00, 8'h00);
    put_field(2, 8'h40, 8'h00, 8'h00);
    put_field(3, 8'h80, 8'h00, 8'h00);
    put_field(4, 8'hF0, 8'h00, 8'h00);
    put_field(5, HEADER_BYTE, HEADER_BYTE, HEADER_BYTE);
    put_field(6, 8'h0A, 8'hBC, 8'hDE);
    put_field(7, 8'h01, 8'h23, 8'h45);
    put_field(8, 8'h89, 8'h87, 8'h65);
    frame_buf[LAST_POS] = 8'h5A;
    send_frame_buf();

    run_phase(11, 85, 10, 0);
    run_phase(85, 11, 10, 0);
    run_phase(0, 0, 10, 400);

    sb.close();
    $display("run covered %0d byte transfers (%0d dropped outside frames), %0d frames matched",
             sb.accepted, sb.dropped, sb.frames_ok);
    $display("mismatches counted: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("bcd_sensor_frame_deframer_test: PASS");
    end else begin
      $display("bcd_sensor_frame_deframer_test: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/bsfd_pkg.sv
src/bsfd_if.sv
src/bsfd_framer.sv
src/bsfd_decoder.sv
src/bcd_sensor_frame_deframer.sv
tb/bcd_sensor_frame_deframer_test.sv
